### rtl/core/iat_pkg.sv
// ----------------------------------------------------------------------------
// iat_pkg
// Types and constants shared by the in-flight ack tracker modules.
// ----------------------------------------------------------------------------
`default_nettype none

package iat_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int TAG_W       = 32;

  localparam logic [1:0] OUTCOME_DELIVERED = 2'd0;
  localparam logic [1:0] OUTCOME_LOST      = 2'd1;
  localparam logic [1:0] OUTCOME_DROPPED   = 2'd2;

  localparam logic MODE_REGISTER = 1'b0;
  localparam logic MODE_ACK      = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [TAG_W-1:0] tag;
    logic             ack_only;
  } item_t;

  typedef struct packed {
    logic [1:0]       outcome;
    logic [TAG_W-1:0] result_tag;
    logic             last;
  } result_t;

  // command handed from front to back; ack-only registers never get here
  typedef struct packed {
    logic             is_ack;
    logic [TAG_W-1:0] tag;
  } cmd_t;

endpackage

`default_nettype wire

### rtl/core/iat_front.sv
// ----------------------------------------------------------------------------
// iat_front
// Accepts input beats, drops ack-only registers, and queues commands for
// the back end in a two-entry command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module iat_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire iat_pkg::item_t item,
  output logic               busy,
  output logic               cmd_valid,
  output iat_pkg::cmd_t      cmd,
  input  wire logic          cmd_pop
);
  import iat_pkg::*;

  cmd_t        q [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        accept;
  logic        push;

  assign busy      = (count == 2'd2);
  assign accept    = start && !busy;
  assign push      = accept && !(item.mode == MODE_REGISTER && item.ack_only);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr].is_ack <= (item.mode == MODE_ACK);
      q[wr_ptr].tag    <= item.tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (cmd_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(cmd_pop);
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> cmd_valid) else $error("pop from empty command queue");
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    busy |-> !push) else $error("push into full command queue");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !cmd_pop) |=> count == $past(count) + 2'd1)
    else $error("command count did not advance");

endmodule

`default_nettype wire

### rtl/core/iat_back.sv
// ----------------------------------------------------------------------------
// iat_back
// Holds the ring of in-flight tags and executes commands: pushes register
// commands (a drop beat when the ring is full), scans the head for ack commands one entry per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module iat_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  input  wire iat_pkg::cmd_t cmd,
  output logic               cmd_pop,
  output logic               strobe,
  output iat_pkg::result_t   result
);
  import iat_pkg::*;

  localparam int SUM_W = PTR_W + 1;
  localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [TAG_W-1:0] mem [QUEUE_DEPTH];
  logic [TAG_W-1:0] rd_data;

  logic [1:0]       state, state_next;
  logic [PTR_W-1:0] head, head_next;
  logic [CNT_W-1:0] count, count_next;
  logic [TAG_W-1:0] ack_tag;
  logic             pend_valid, pend_valid_next;
  result_t          pend, pend_data;
  logic             pend_load;
  logic             strobe_next;
  result_t          out_data;
  logic             pop;
  logic             wr_en;
  logic [SUM_W-1:0] tail_sum;
  logic [PTR_W-1:0] tail;

  assign tail_sum = SUM_W'(head) + SUM_W'(count);
  assign tail     = (tail_sum >= DEPTH_S) ? PTR_W'(tail_sum - DEPTH_S)
                                          : PTR_W'(tail_sum);

  always_comb begin
    state_next      = state;
    count_next      = count;
    pend_valid_next = pend_valid;
    pend_load       = 1'b0;
    pend_data       = pend;
    strobe_next     = 1'b0;
    out_data        = pend;
    out_data.last   = 1'b0;
    pop             = 1'b0;
    wr_en           = 1'b0;
    cmd_pop         = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          if (!cmd.is_ack) begin
            if (count == DEPTH_C) begin
              strobe_next         = 1'b1;
              out_data.outcome    = OUTCOME_DROPPED;
              out_data.result_tag = cmd.tag;
              out_data.last       = 1'b1;
            end else begin
              wr_en      = 1'b1;
              count_next = count + CNT_W'(1);
            end
          end else if (count != '0) begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (rd_data <= ack_tag) begin
          strobe_next          = pend_valid;
          pop                  = 1'b1;
          count_next           = count - CNT_W'(1);
          pend_load            = 1'b1;
          pend_valid_next      = 1'b1;
          pend_data.outcome    = (rd_data == ack_tag) ? OUTCOME_DELIVERED : OUTCOME_LOST;
          pend_data.result_tag = rd_data;
          pend_data.last       = 1'b0;
          if (rd_data == ack_tag || count == CNT_W'(1)) state_next = S_FLUSH;
        end else begin
          state_next = pend_valid ? S_FLUSH : S_IDLE;
        end
      end
      S_FLUSH: begin
        strobe_next     = 1'b1;
        out_data.last   = 1'b1;
        pend_valid_next = 1'b0;
        state_next      = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    head_next = pop ? ((head == LAST_PTR) ? '0 : head + PTR_W'(1)) : head;
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[tail] <= cmd.tag;
    rd_data <= mem[head_next];
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) ack_tag <= cmd.tag;
    if (pend_load) pend <= pend_data;
    if (strobe_next) result <= out_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      count      <= '0;
      pend_valid <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      state      <= state_next;
      head       <= head_next;
      count      <= count_next;
      pend_valid <= pend_valid_next;
      strobe     <= strobe_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C) else $error("entry count above depth");
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !pend_valid) else $error("pending result left in idle");
  a_flush_last: assert property (@(posedge clk) disable iff (rst)
    state == S_FLUSH |=> strobe && result.last) else $error("flush without last beat");
  a_drop_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.outcome == OUTCOME_DROPPED) |-> result.last)
    else $error("drop beat not marked last");

endmodule

`default_nettype wire

### rtl/core/in_flight_ack_tracker.sv
// ----------------------------------------------------------------------------
// in_flight_ack_tracker
// Sender-side tracker of in-flight packet tags with ack resolution.
//
// Input: a beat is taken on a rising edge with start high and busy low.
//   item.mode 0 registers a sent tag (ignored when item.ack_only is set),
//   item.mode 1 carries an acknowledged tag.
// Output: each result beat is valid for one cycle while strobe is high; the
//   receiver cannot stall, so results are never held back. result.last marks
//   the final beat caused by one input.
// A two-entry command queue decouples intake from execution; busy rises only
// when it is full. A register is executed by the back end in its idle state,
// and its drop beat, if any, is registered out of that state. An ack scans
// the ring head one entry per ring read; a match or an emptied ring moves to
// a flush state that sends the last beat. A larger head tag stops the scan,
// flushing the pending beat if there is one and else giving no beat; an ack
// on an empty ring is finished in the idle state.
// Reset (rst, synchronous) empties the ring and the command queue; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module in_flight_ack_tracker (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire iat_pkg::item_t   item,
  output logic                  busy,
  output logic                  strobe,
  output iat_pkg::result_t      result
);
  import iat_pkg::*;

  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  iat_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .busy      (busy),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  iat_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .strobe    (strobe),
    .result    (result)
  );

endmodule

`default_nettype wire
